>>> rtl/pwli_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the piecewise linear interpolator.
// No dependencies; imported by the top level.
package pwli_pkg;

	typedef enum logic [0:0] {
		FUNC_WRITE = 1'b0,
		FUNC_EVAL  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_SAT  = 2'd1,
		STAT_ZERO = 2'd2
	} stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SEG_RD,
		ST_SEG_LD,
		ST_ONE_RD,
		ST_ONE_LD,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} state_t;

	localparam logic [0:0]  REG_POINT_COUNT = 1'b0;
	localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;
	localparam int          MUL_STEPS = 32;
	localparam int          DIV_STEPS = 64;

endpackage

>>> rtl/piecewise_linear_interpolator_top.sv
`timescale 1ns / 1ps
// Piecewise linear interpolator: breakpoint table, search, bit-serial multiply and divide.
// Depends on pwli_pkg.
// A write transaction is taken in the idle state. An evaluation searches up to MAX_POINTS - 1
// breakpoints through the registered table read port, then runs the 32-step shift-add
// multiplier and the 64-step divider. A zero-width segment skips the arithmetic, one point
// skips the search and the arithmetic, and no points give a zero result. Once the result
// is loaded into the output register, the block returns to idle for the next transaction.
// One evaluation is in work at a time; a finished result waits in the output register.
// arst_n clears control state and point_count; the table is undefined until written.
module piecewise_linear_interpolator_top #(
	parameter int MAX_POINTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// point_index[3:0], x_value[35:4], y_value[67:36], zero pad
	input  logic [71:0] s_axis_tdata,
	// func[0]
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// result_y[31:0], status[33:32], zero pad
	output logic [39:0] m_axis_tdata
);
	import pwli_pkg::*;

	localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	state_t state_q, state_d;

	logic [4:0]       point_count_q;
	logic [31:0]      mem_x_q [MAX_POINTS];
	logic [31:0]      mem_y_q [MAX_POINTS];
	logic [IDX_W-1:0] rd_addr_q;
	logic [31:0]      rx_q, ry_q;
	logic [CNT_W-1:0] n_q;
	logic [31:0]      xq_q, x1_q, y1_q, y0_q;
	logic [31:0]      dx_mag_q, mcand_q, rem_q;
	logic             neg_q;
	logic [63:0]      prod_q;
	logic [5:0]       step_q;
	logic [31:0]      res_q;
	stat_t            stat_q;
	logic             out_valid_q;
	logic [31:0]      out_res_q;
	stat_t            out_stat_q;

	// Input fields
	logic             in_accept;
	func_t            in_func;
	logic [3:0]       in_idx;
	logic [31:0]      in_x, in_y;
	logic [CNT_W-1:0] n_in;
	logic             out_load;

	assign in_func = func_t'(s_axis_tuser);
	assign in_idx  = s_axis_tdata[3:0];
	assign in_x    = s_axis_tdata[35:4];
	assign in_y    = s_axis_tdata[67:36];
	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign n_in = (32'(point_count_q) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
		: CNT_W'(point_count_q);

	// Configuration port
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_POINT_COUNT) ? {27'd0, point_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= 5'd0;
		end else if (cfg_wr && paddr[2] == REG_POINT_COUNT) begin
			point_count_q <= pwdata[4:0];
		end
	end

	// Search and segment arithmetic
	logic        hit;
	logic [32:0] dx_w, dy_w, t_w;
	logic [32:0] dx_abs, dy_abs, t_abs;
	logic [32:0] mul_sum;
	logic [32:0] rem_sh;
	logic        div_ge;
	logic [32:0] rem_sub;
	logic        q_big;
	logic [35:0] sum36;

	assign hit = ($signed(xq_q) < $signed(rx_q)) || (CNT_W'(rd_addr_q) == n_q - 1'b1);
	assign dx_w = {x1_q[31], x1_q} - {rx_q[31], rx_q};
	assign dy_w = {y1_q[31], y1_q} - {ry_q[31], ry_q};
	assign t_w  = {xq_q[31], xq_q} - {rx_q[31], rx_q};
	assign dx_abs = dx_w[32] ? (33'd0 - dx_w) : dx_w;
	assign dy_abs = dy_w[32] ? (33'd0 - dy_w) : dy_w;
	assign t_abs  = t_w[32] ? (33'd0 - t_w) : t_w;

	assign mul_sum = {1'b0, prod_q[63:32]} + (prod_q[0] ? {1'b0, mcand_q} : 33'd0);
	assign rem_sh  = {rem_q, prod_q[63]};
	assign div_ge  = rem_sh >= {1'b0, dx_mag_q};
	assign rem_sub = rem_sh - {1'b0, dx_mag_q};

	// The quotient limit is 2^34; above it the sum is certain to saturate.
	assign q_big = (|prod_q[63:35]) || (prod_q[34] && (|prod_q[33:0]));
	assign sum36 = neg_q ? ({{4{y0_q[31]}}, y0_q} - {1'b0, prod_q[34:0]})
		: ({{4{y0_q[31]}}, y0_q} + {1'b0, prod_q[34:0]});

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && in_func == FUNC_EVAL) begin
					if (n_in == '0)
						state_d = ST_EMIT;
					else if (n_in == CNT_W'(1))
						state_d = ST_ONE_RD;
					else
						state_d = ST_SRCH_RD;
				end
			end
			ST_SRCH_RD:  state_d = ST_SRCH_CMP;
			ST_SRCH_CMP: state_d = hit ? ST_SEG_RD : ST_SRCH_RD;
			ST_SEG_RD:   state_d = ST_SEG_LD;
			ST_SEG_LD:   state_d = (dx_w == 33'd0) ? ST_EMIT : ST_MUL;
			ST_ONE_RD:   state_d = ST_ONE_LD;
			ST_ONE_LD:   state_d = ST_EMIT;
			ST_MUL:      state_d = (step_q == 6'(MUL_STEPS - 1)) ? ST_DIV : ST_MUL;
			ST_DIV:      state_d = (step_q == 6'(DIV_STEPS - 1)) ? ST_FIN : ST_DIV;
			ST_FIN:      state_d = ST_EMIT;
			ST_EMIT:     state_d = out_load ? ST_IDLE : ST_EMIT;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Outputs of the controller
	always_comb begin
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_EMIT: out_load = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// Breakpoint table: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (in_accept && in_func == FUNC_WRITE && 32'(in_idx) < 32'(MAX_POINTS)) begin
			mem_x_q[IDX_W'(in_idx)] <= in_x;
			mem_y_q[IDX_W'(in_idx)] <= in_y;
		end
		rx_q <= mem_x_q[rd_addr_q];
		ry_q <= mem_y_q[rd_addr_q];
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				xq_q      <= in_x;
				n_q       <= n_in;
				rd_addr_q <= (n_in == CNT_W'(1)) ? IDX_W'(0) : IDX_W'(1);
				res_q     <= 32'd0;
				stat_q    <= STAT_OK;
			end
			ST_SRCH_CMP: begin
				if (hit) begin
					x1_q      <= rx_q;
					y1_q      <= ry_q;
					rd_addr_q <= rd_addr_q - 1'b1;
				end else begin
					rd_addr_q <= rd_addr_q + 1'b1;
				end
			end
			ST_SEG_LD: begin
				y0_q     <= ry_q;
				res_q    <= ry_q;
				stat_q   <= STAT_ZERO;
				dx_mag_q <= dx_abs[31:0];
				mcand_q  <= dy_abs[31:0];
				prod_q   <= {32'd0, t_abs[31:0]};
				neg_q    <= (dy_w[32] ^ t_w[32]) ^ dx_w[32];
				rem_q    <= 32'd0;
				step_q   <= 6'd0;
			end
			ST_ONE_LD: begin
				res_q  <= ry_q;
				stat_q <= STAT_OK;
			end
			ST_MUL: begin
				prod_q <= {mul_sum, prod_q[31:1]};
				step_q <= (step_q == 6'(MUL_STEPS - 1)) ? 6'd0 : step_q + 6'd1;
			end
			ST_DIV: begin
				rem_q  <= div_ge ? rem_sub[31:0] : rem_sh[31:0];
				prod_q <= {prod_q[62:0], div_ge};
				step_q <= step_q + 6'd1;
			end
			ST_FIN: begin
				if (q_big) begin
					res_q  <= neg_q ? Q_MIN : Q_MAX;
					stat_q <= STAT_SAT;
				end else if ($signed(sum36) > $signed({4'd0, Q_MAX})) begin
					res_q  <= Q_MAX;
					stat_q <= STAT_SAT;
				end else if ($signed(sum36) < $signed({4'hf, Q_MIN})) begin
					res_q  <= Q_MIN;
					stat_q <= STAT_SAT;
				end else begin
					res_q  <= sum36[31:0];
					stat_q <= STAT_OK;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_res_q  <= res_q;
			out_stat_q <= stat_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_stat_q, out_res_q};

	a_div_rem_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> (rem_q < dx_mag_q))
		else $error("divider remainder not below divisor");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> dx_mag_q != 32'd0)
		else $error("zero-width segment entered the multiplier");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_stat_q == STAT_SAT) |->
			(out_res_q == Q_MAX || out_res_q == Q_MIN))
		else $error("saturated result not at a limit");

	a_emit_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && $past(state_q) == ST_EMIT)
		else $error("result loaded outside emit state");

endmodule
